FILE: rtl/wsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [2:0] KIND_TEXT  = 3'd0;
  localparam logic [2:0] KIND_BIN   = 3'd1;
  localparam logic [2:0] KIND_CONT  = 3'd2;
  localparam logic [2:0] KIND_CLOSE = 3'd3;
  localparam logic [2:0] KIND_PING  = 3'd4;
  localparam logic [2:0] KIND_PONG  = 3'd5;
  localparam logic [2:0] KIND_ERROR = 3'd6;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;
  localparam logic [3:0] MASK_BYTES    = 4'd4;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [2:0] frame_kind;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/websocket_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket deframer: header parsing and payload unmasking.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/data_byte) carries the frame stream, one
// byte per request. Output channel (out_valid/out_ready) carries a result
// per payload byte, plus one for the last header byte of an empty frame;
// other header bytes give no result.
// A result is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while the result register is free, set by the
// parser state update feeding the one-entry result register.
// in_ready = !out_valid || out_ready: a held result that is being taken
// still lets the next byte in the same cycle.
// Receiver stall: the result holds in the output register and input stops
// only while that register is full and not taken.
// Reset: synchronous; parser returns to the first header byte, fragment
// type clears to text, output register empties.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            has_payload,
  output logic [7:0]      payload_byte,
  output logic            frame_end,
  output logic [2:0]      frame_kind
);
  import wsd_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  result_t held;

  assign step = in_valid && in_ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (data_byte),
    .res       (res),
    .res_valid (res_valid)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (step && res_valid),
    .res       (res),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign has_payload  = held.has_payload;
  assign payload_byte = held.payload_byte;
  assign frame_end    = held.frame_end;
  assign frame_kind   = held.frame_kind;

endmodule
`default_nettype wire

FILE: rtl/wsd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_parser
// Header/payload state machine; a result per payload byte or empty frame.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  output wsd_pkg::result_t      res,
  output logic                  res_valid
);
  import wsd_pkg::*;

  logic [2:0]  phase, phase_next;
  logic        fin_flag, fin_flag_next;
  logic [3:0]  opcode_seen, opcode_seen_next;
  logic        masked_flag, masked_flag_next;
  logic [3:0]  header_bytes_left, header_bytes_left_next;
  logic [63:0] payload_left, payload_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_index, mask_index_next;
  logic        binary_continuation, binary_continuation_next;

  logic        hdr_done;
  logic [63:0] hdr_len;
  logic        finish;
  logic [3:0]  hbl_dec;
  logic [7:0]  mask_byte;
  logic [2:0]  kind;

  always_comb begin
    unique case (opcode_seen)
      OP_CONT:  kind = fin_flag ? (binary_continuation ? KIND_BIN : KIND_TEXT) : KIND_CONT;
      OP_TEXT:  kind = fin_flag ? KIND_TEXT : KIND_CONT;
      OP_BIN:   kind = fin_flag ? KIND_BIN : KIND_CONT;
      OP_CLOSE: kind = KIND_CLOSE;
      OP_PING:  kind = KIND_PING;
      OP_PONG:  kind = KIND_PONG;
      default:  kind = KIND_ERROR;
    endcase
  end

  always_comb begin
    unique case (mask_index)
      2'd0:    mask_byte = mask_key[31:24];
      2'd1:    mask_byte = mask_key[23:16];
      2'd2:    mask_byte = mask_key[15:8];
      default: mask_byte = mask_key[7:0];
    endcase
  end

  assign hbl_dec = header_bytes_left - 4'd1;

  always_comb begin
    phase_next               = phase;
    fin_flag_next            = fin_flag;
    opcode_seen_next         = opcode_seen;
    masked_flag_next         = masked_flag;
    header_bytes_left_next   = header_bytes_left;
    payload_left_next        = payload_left;
    mask_key_next            = mask_key;
    mask_index_next          = mask_index;
    binary_continuation_next = binary_continuation;
    hdr_done  = 1'b0;
    hdr_len   = payload_left;
    finish    = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase)
      PH_HDR1: begin
        masked_flag_next = data_byte[7];
        mask_key_next    = '0;
        mask_index_next  = '0;
        if (data_byte[6:0] <= LEN_MAX_SHORT) begin
          payload_left_next = {57'd0, data_byte[6:0]};
          hdr_len           = {57'd0, data_byte[6:0]};
          if (data_byte[7]) begin
            header_bytes_left_next = MASK_BYTES;
            phase_next             = PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end else begin
          payload_left_next      = '0;
          header_bytes_left_next = (data_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_next             = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        payload_left_next      = {payload_left[55:0], data_byte};
        hdr_len                = {payload_left[55:0], data_byte};
        header_bytes_left_next = hbl_dec;
        if (hbl_dec == 4'd0) begin
          if (masked_flag) begin
            header_bytes_left_next = MASK_BYTES;
            phase_next             = PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_MASK: begin
        mask_key_next          = {mask_key[23:0], data_byte};
        header_bytes_left_next = hbl_dec;
        if (hbl_dec == 4'd0) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        mask_index_next   = mask_index + 2'd1;
        payload_left_next = payload_left - 64'd1;
        res_valid         = 1'b1;
        res.has_payload   = 1'b1;
        res.payload_byte  = masked_flag ? (data_byte ^ mask_byte) : data_byte;
        if (payload_left == 64'd1) begin
          finish = 1'b1;
        end
      end
      default: begin
        fin_flag_next    = data_byte[7];
        opcode_seen_next = data_byte[3:0];
        phase_next       = PH_HDR1;
      end
    endcase

    if (hdr_done) begin
      if (hdr_len == 64'd0) begin
        res_valid = 1'b1;
        finish    = 1'b1;
      end else begin
        mask_index_next = '0;
        phase_next      = PH_PAYLOAD;
      end
    end

    if (finish) begin
      res.frame_end  = 1'b1;
      res.frame_kind = kind;
      phase_next     = PH_HDR0;
      if (!fin_flag && (opcode_seen == OP_TEXT || opcode_seen == OP_BIN)) begin
        binary_continuation_next = (opcode_seen == OP_BIN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HDR0;
      fin_flag            <= 1'b0;
      opcode_seen         <= '0;
      masked_flag         <= 1'b0;
      header_bytes_left   <= '0;
      payload_left        <= '0;
      mask_key            <= '0;
      mask_index          <= '0;
      binary_continuation <= 1'b0;
    end else if (step) begin
      phase               <= phase_next;
      fin_flag            <= fin_flag_next;
      opcode_seen         <= opcode_seen_next;
      masked_flag         <= masked_flag_next;
      header_bytes_left   <= header_bytes_left_next;
      payload_left        <= payload_left_next;
      mask_key            <= mask_key_next;
      mask_index          <= mask_index_next;
      binary_continuation <= binary_continuation_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wsd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register between the parser and the output channel.
// ----------------------------------------------------------------------------
module wsd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire wsd_pkg::result_t res,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wsd_pkg::result_t      held
);
  import wsd_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire
